// File: sv/smu_pkg.sv
// ----------------------------------------------------------------------------
// smu_pkg
// Shared types, constants and lookup tables for the spin-one update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smu_pkg;

  localparam int SIDE_W     = 6;
  localparam int SIDE       = 1 << SIDE_W;
  localparam int SITES      = SIDE * SIDE;
  localparam int ADDR_W     = 2 * SIDE_W;
  localparam int SITE_W     = 12;
  localparam int SPIN_W     = 2;
  localparam int FIELD_W    = 15;
  localparam int COUPLE_W   = 15;
  localparam int BETA_W     = 16;
  localparam int UNI_W      = 16;
  localparam int SUM_W      = 14;
  localparam int ZERO_W     = 13;
  localparam int DROP_W     = 20;
  localparam int PAIR_W     = COUPLE_W + 2;
  localparam int MUL_A_W    = 18;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int FRAC_SHIFT = 16;
  localparam int Q_W        = PROD_W - FRAC_SHIFT;
  localparam int EXP_STEPS  = 12;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TRIAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COUPLING_MIXED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING_OPPOSITE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTERNAL_FIELD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TEMPERATURE   = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_SITE,
    ST_LD_OLD,
    ST_RD_N0,
    ST_RD_N1,
    ST_RD_N2,
    ST_RD_N3,
    ST_ACC_LAST,
    ST_DECIDE,
    ST_EXP_LOOK,
    ST_COMPARE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic              spin_we;
    logic              field_we;
    logic [ADDR_W-1:0] addr;
    logic [SPIN_W-1:0] spin;
    logic [FIELD_W-1:0] field;
  } lat_wr_t;

  function automatic logic [MUL_B_W-1:0] exp_int_f(input logic [3:0] n);
    logic [MUL_B_W-1:0] v;
    unique case (n)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [MUL_B_W-1:0] exp_frac_f(input logic [3:0] f);
    logic [MUL_B_W-1:0] v;
    unique case (f)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd61565;
      4'd2:  v = 17'd57835;
      4'd3:  v = 17'd54331;
      4'd4:  v = 17'd51039;
      4'd5:  v = 17'd47947;
      4'd6:  v = 17'd45042;
      4'd7:  v = 17'd42313;
      4'd8:  v = 17'd39750;
      4'd9:  v = 17'd37341;
      4'd10: v = 17'd35079;
      4'd11: v = 17'd32954;
      4'd12: v = 17'd30957;
      4'd13: v = 17'd29081;
      4'd14: v = 17'd27319;
      4'd15: v = 17'd25664;
    endcase
    return v;
  endfunction

endpackage

// File: sv/spin_one_metropolis_update.sv
// ----------------------------------------------------------------------------
// spin_one_metropolis_update
// A trial stops early when the energy drops and skips the compare step
// when the exponent saturates; a load is shorter. One request at a time.
// The single memory read port, one site and four neighbours in turn, and two
// passes through the shared multiplier set the trial length.
// After reset a clearing pass over the 4096 sites zeroes the lattice;
// in_tready stays low meanwhile while configuration writes are still taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spin_one_metropolis_update import smu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // site[11:0], spin_value[13:12], field_value[28:14], proposal_bit[29],
  // uniform[45:30], zero fill[47:46]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // accepted[0], site_spin[2:1], spin_sum[16:3], zero_count[29:17],
  // zero fill[31:30]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]          clr_r;
  logic [COUPLE_W-1:0]        mixed_r;
  logic [COUPLE_W-1:0]        opposite_r;
  logic signed [FIELD_W-1:0]  ext_r;
  logic [BETA_W-1:0]          beta_r;
  logic signed [SUM_W-1:0]    spin_total_r, spin_total_nxt;
  logic [ZERO_W-1:0]          zero_total_r, zero_total_nxt;
  logic                       out_valid_r;
  logic [OUT_TDATA_W-1:0]     out_data_r;

  logic                       cmd_r;
  logic [SITE_W-1:0]          site_r;
  logic                       site_ok_r;
  logic [FIELD_W-1:0]         field_r;
  logic                       prop_r;
  logic [UNI_W-1:0]           uni_r;
  logic signed [SPIN_W-1:0]   old_r;
  logic signed [SPIN_W-1:0]   nw_r;
  logic signed [DROP_W-1:0]   drop_r;
  logic                       acc_r;
  logic                       chg_r;

  logic                       in_fire;
  logic                       commit_go;
  logic [SPIN_W-1:0]          in_spin_sat;
  logic                       in_site_ok;
  logic [SIDE_W-1:0]          row, col;
  logic [ADDR_W-1:0]          site_addr;
  logic [ADDR_W-1:0]          rd_addr;
  logic [SPIN_W-1:0]          rd_spin;
  logic [FIELD_W-1:0]         rd_field;
  lat_wr_t                    wr;
  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [PROD_W-1:0]          mul_prod;
  logic [PROD_W-1:0]          rnd_sum;
  logic [Q_W-1:0]             q_val;
  logic                       exp_sat;
  logic                       win;
  logic signed [SPIN_W-1:0]   old_c;
  logic signed [SPIN_W-1:0]   nw_c;
  logic signed [DROP_W-1:0]   init_c;
  logic signed [DROP_W-1:0]   neg_drop;
  logic signed [PAIR_W-1:0]   pd_c;
  logic signed [SPIN_W-1:0]   now_c;

  function automatic logic [COUPLE_W-1:0] pair_f(
    input logic signed [SPIN_W-1:0] a,
    input logic signed [SPIN_W-1:0] b,
    input logic [COUPLE_W-1:0]      jm,
    input logic [COUPLE_W-1:0]      jo
  );
    logic [COUPLE_W-1:0] e;
    e = '0;
    if ((a == 0) != (b == 0)) begin
      e = jm;
    end else if ((a != 0) && (b != 0) && (a != b)) begin
      e = jo;
    end
    return e;
  endfunction

  smu_lattice u_lattice (
    .clk      (clk),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_spin  (rd_spin),
    .rd_field (rd_field)
  );

  smu_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  assign in_fire     = in_tvalid && in_tready;
  assign commit_go   = (state_r == ST_COMMIT) && (!out_valid_r || out_tready);
  assign in_spin_sat = (in_tdata[13:12] == 2'b10) ? 2'b11 : in_tdata[13:12];
  assign in_site_ok  = int'(in_tdata[SITE_W-1:0]) < SITES;
  assign site_addr   = site_r[ADDR_W-1:0];
  assign row         = site_addr[ADDR_W-1:SIDE_W];
  assign col         = site_addr[SIDE_W-1:0];

  assign rnd_sum = mul_prod + PROD_W'(1 << (FRAC_SHIFT - 1));
  assign q_val   = rnd_sum[PROD_W-1:FRAC_SHIFT];
  assign exp_sat = q_val[Q_W-1:4] >= (Q_W - 4)'(EXP_STEPS);
  assign win     = Q_W'(uni_r) < q_val;

  assign old_c    = $signed(rd_spin);
  assign neg_drop = -drop_r;

  always_comb begin
    if (old_c == 0) begin
      nw_c = prop_r ? 2'sd1 : -2'sd1;
    end else if (old_c == 1) begin
      nw_c = prop_r ? 2'sd0 : -2'sd1;
    end else begin
      nw_c = prop_r ? 2'sd1 : 2'sd0;
    end
  end

  always_comb begin
    logic signed [DROP_W-1:0] fterm;
    logic signed [DROP_W-1:0] ext_w;
    logic signed [DROP_W-1:0] eterm;
    logic signed [2:0]        dspin;
    ext_w = DROP_W'(ext_r);
    dspin = 3'(old_c) - 3'(nw_c);
    if (old_c == 0) begin
      fterm = -DROP_W'($signed(rd_field));
    end else if (nw_c == 0) begin
      fterm = DROP_W'($signed(rd_field));
    end else begin
      fterm = '0;
    end
    unique case (dspin)
      3'sd1:   eterm = ext_w;
      -3'sd1:  eterm = -ext_w;
      3'sd2:   eterm = ext_w <<< 1;
      -3'sd2:  eterm = -(ext_w <<< 1);
      default: eterm = '0;
    endcase
    init_c = fterm - eterm;
  end

  assign pd_c = $signed(PAIR_W'(pair_f(old_r, $signed(rd_spin), mixed_r, opposite_r)))
              - $signed(PAIR_W'(pair_f(nw_r, $signed(rd_spin), mixed_r, opposite_r)));

  always_comb begin
    if (!site_ok_r) begin
      now_c = '0;
    end else if (chg_r) begin
      now_c = nw_r;
    end else begin
      now_c = old_r;
    end
  end

  always_comb begin
    spin_total_nxt = spin_total_r;
    zero_total_nxt = zero_total_r;
    if (chg_r && site_ok_r) begin
      spin_total_nxt = spin_total_r + SUM_W'(nw_r) - SUM_W'(old_r);
      zero_total_nxt = zero_total_r - ZERO_W'(old_r == 0) + ZERO_W'(nw_r == 0);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == ADDR_W'(SITES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = in_site_ok ? ST_RD_SITE : ST_COMMIT;
        end
      end
      ST_RD_SITE:  state_nxt = (cmd_r == CMD_LOAD) ? ST_LD_OLD : ST_RD_N0;
      ST_LD_OLD:   state_nxt = ST_COMMIT;
      ST_RD_N0:    state_nxt = ST_RD_N1;
      ST_RD_N1:    state_nxt = ST_RD_N2;
      ST_RD_N2:    state_nxt = ST_RD_N3;
      ST_RD_N3:    state_nxt = ST_ACC_LAST;
      ST_ACC_LAST: state_nxt = ST_DECIDE;
      ST_DECIDE:   state_nxt = (drop_r > 0) ? ST_COMMIT : ST_EXP_LOOK;
      ST_EXP_LOOK: state_nxt = exp_sat ? ST_COMMIT : ST_COMPARE;
      ST_COMPARE:  state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (commit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    rd_addr   = site_addr;
    wr        = '0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_CLEAR: begin
        wr.spin_we  = 1'b1;
        wr.field_we = 1'b1;
        wr.addr     = clr_r;
      end
      ST_IDLE:  in_tready = 1'b1;
      ST_RD_N0: rd_addr = {row, col - SIDE_W'(1)};
      ST_RD_N1: rd_addr = {row, col + SIDE_W'(1)};
      ST_RD_N2: rd_addr = {row - SIDE_W'(1), col};
      ST_RD_N3: rd_addr = {row + SIDE_W'(1), col};
      ST_DECIDE: begin
        mul_a = neg_drop[MUL_A_W-1:0];
        mul_b = MUL_B_W'(beta_r);
      end
      ST_EXP_LOOK: begin
        mul_a = MUL_A_W'(exp_int_f(q_val[7:4]));
        mul_b = exp_frac_f(q_val[3:0]);
      end
      ST_COMMIT: begin
        if (commit_go) begin
          wr.spin_we  = chg_r && site_ok_r;
          wr.field_we = (cmd_r == CMD_LOAD) && site_ok_r;
          wr.addr     = site_addr;
          wr.spin     = nw_r;
          wr.field    = field_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      spin_total_r <= '0;
      zero_total_r <= ZERO_W'(SITES);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      if (commit_go) begin
        spin_total_r <= spin_total_nxt;
        zero_total_r <= zero_total_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mixed_r    <= COUPLE_W'(4096);
      opposite_r <= COUPLE_W'(4096);
      ext_r      <= '0;
      beta_r     <= BETA_W'(640);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUPLING_MIXED:    mixed_r    <= cfg_wdata[COUPLE_W-1:0];
        REG_COUPLING_OPPOSITE: opposite_r <= cfg_wdata[COUPLE_W-1:0];
        REG_EXTERNAL_FIELD:    ext_r      <= $signed(cfg_wdata[FIELD_W-1:0]);
        REG_INV_TEMPERATURE:   beta_r     <= cfg_wdata[BETA_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_data_r <= {2'b00, zero_total_nxt, spin_total_nxt, now_c, acc_r};
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_r     <= in_tuser;
          site_r    <= in_tdata[11:0];
          site_ok_r <= in_site_ok;
          nw_r      <= $signed(in_spin_sat);
          field_r   <= in_tdata[28:14];
          prop_r    <= in_tdata[29];
          uni_r     <= in_tdata[45:30];
          acc_r     <= 1'b0;
          chg_r     <= 1'b0;
        end
      end
      ST_LD_OLD: begin
        old_r <= old_c;
        chg_r <= 1'b1;
      end
      ST_RD_N0: begin
        old_r  <= old_c;
        nw_r   <= nw_c;
        drop_r <= init_c;
      end
      ST_RD_N1, ST_RD_N2, ST_RD_N3, ST_ACC_LAST: begin
        drop_r <= drop_r + DROP_W'(pd_c);
      end
      ST_DECIDE: begin
        if (drop_r > 0) begin
          acc_r <= 1'b1;
          chg_r <= 1'b1;
        end
      end
      ST_COMPARE: begin
        if (win) begin
          acc_r <= 1'b1;
          chg_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("Block took a request while a previous one was in work.");

  a_totals_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(spin_total_r) + int'(zero_total_r) <= SITES) &&
    (int'(zero_total_r) - int'(spin_total_r) <= SITES))
    else $error("Spin sum and zero count disagree with the lattice size.");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_COMMIT))
    else $error("Result appeared without a commit step.");
`endif

endmodule

// File: sv/smu_mul.sv
// ----------------------------------------------------------------------------
// smu_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smu_mul import smu_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic [PROD_W-1:0]  prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

// File: sv/smu_lattice.sv
// ----------------------------------------------------------------------------
// smu_lattice
// Spin and random field memories, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smu_lattice import smu_pkg::*; (
  input  logic               clk,
  input  lat_wr_t            wr,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [SPIN_W-1:0]  rd_spin,
  output logic [FIELD_W-1:0] rd_field
);

  logic [SPIN_W-1:0]  spin_mem  [SITES];
  logic [FIELD_W-1:0] field_mem [SITES];
  logic [SPIN_W-1:0]  rd_spin_r;
  logic [FIELD_W-1:0] rd_field_r;

  always_ff @(posedge clk) begin
    if (wr.spin_we) begin
      spin_mem[wr.addr] <= wr.spin;
    end
    rd_spin_r <= spin_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.field_we) begin
      field_mem[wr.addr] <= wr.field;
    end
    rd_field_r <= field_mem[rd_addr];
  end

  assign rd_spin  = rd_spin_r;
  assign rd_field = rd_field_r;

endmodule
